FILE: src/slt_pkg.sv
// Package for the scytale letter transposer.
// Holds sizing defaults, character codes and the letter test; no dependencies.
package slt_pkg;

    // Default text capacity in bytes
    localparam int unsigned MAX_LEN_DEFAULT = 1024;

    // Reset number of rods (grid columns)
    localparam logic [7:0] ROD_RESET = 8'd4;

    // Register map, by register index
    localparam logic REG_ROD_COUNT = 1'b0;

    // Request kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    // Control state of the fetch sequencer
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } slt_state_t;

    // True for A-Z and a-z
    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
                 || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

endpackage

FILE: src/scytale_letter_transposer_top.sv
// Top level of the scytale letter transposer: text and letter memories,
// load/fetch sequencing and the APB configuration register.
// Depends on slt_pkg.
//
// Usage:
//   Requests enter on start/busy with action, in_byte and in_last. A load
//   (action 0) writes one byte in the cycle it is accepted; the next
//   request may follow straight away. A fetch (action 1) reads both
//   memories at acceptance, resolves the byte in the following cycle and
//   presents it from the result registers on out_byte/out_last/out_none
//   for one cycle under out_valid. busy is high for the one cycle of the
//   memory read, so no new request is taken until the fetch resolves.
//   rod_count sits at byte address 0 of the APB port. The user must see
//   that rod_count is written only while no fetch is in flight; the block
//   itself does not enforce this. pready is tied high.
//   Reset clears all counts, pointers, control flags and out_valid, sets
//   rod_count to 4 and leaves the memories and result payload as they are;
//   unwritten memory never reaches the output. No clearing pass is needed.
//   The receiver cannot stall: every result is shown for exactly one cycle.
module scytale_letter_transposer_top
    import slt_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    // result channel
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_none,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
    localparam int unsigned PTR_W  = (CNT_W > 8) ? CNT_W : 8;

    // Memories
    logic [7:0] text_mem   [MAX_LEN];
    logic [7:0] letter_mem [MAX_LEN];
    logic [7:0] text_rd_reg;
    logic [7:0] letter_rd_reg;

    // Control and count registers
    slt_state_t       state_reg, state_next;
    logic [CNT_W-1:0] text_count_reg, text_count_next;
    logic [CNT_W-1:0] letter_total_reg, letter_total_next;
    logic [CNT_W-1:0] out_position_reg, out_position_next;
    logic [7:0]       column_reg, column_next;
    logic [PTR_W-1:0] pointer_reg, pointer_next;
    logic             loaded_reg, loaded_next;
    logic             emitting_reg, emitting_next;
    logic [7:0]       rod_count_reg;

    // Result registers
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             out_none_reg, out_none_next;

    logic             accept;
    logic             load_req;
    logic             fetch_req;
    logic             new_msg;
    logic [CNT_W-1:0] base_text;
    logic [CNT_W-1:0] base_letter;
    logic             text_room;
    logic             letter_wr;
    logic             text_wr;
    logic [7:0]       rods;
    logic [PTR_W:0]   pointer_sum;
    logic             use_letter;
    logic             at_end;
    logic             cfg_wr;

    assign accept    = start && !busy;
    assign load_req  = accept && (action == ACT_LOAD);
    assign fetch_req = accept && (action == ACT_FETCH);
    assign busy      = (state_reg == ST_READ);

    // Load addressing: a load after a finished or emitted message restarts
    assign new_msg     = loaded_reg || emitting_reg;
    assign base_text   = new_msg ? '0 : text_count_reg;
    assign base_letter = new_msg ? '0 : letter_total_reg;
    assign text_room   = (base_text < CNT_W'(MAX_LEN));
    assign text_wr     = load_req && text_room;
    assign letter_wr   = text_wr && is_letter(in_byte)
                      && (base_letter < CNT_W'(MAX_LEN));

    // Text memory: write on load, read at fetch acceptance
    always_ff @(posedge clk)
    begin
        if (text_wr)
        begin
            text_mem[base_text[ADDR_W-1:0]] <= in_byte;
        end
        if (fetch_req)
        begin
            text_rd_reg <= text_mem[out_position_reg[ADDR_W-1:0]];
        end
    end

    // Letter memory: same timing
    always_ff @(posedge clk)
    begin
        if (letter_wr)
        begin
            letter_mem[base_letter[ADDR_W-1:0]] <= in_byte;
        end
        if (fetch_req)
        begin
            letter_rd_reg <= letter_mem[pointer_reg[ADDR_W-1:0]];
        end
    end

    // Fetch resolution, from data read in the previous cycle
    assign rods        = (rod_count_reg == 8'd0) ? 8'd1 : rod_count_reg;
    assign at_end      = (out_position_reg >= text_count_reg);
    assign use_letter  = is_letter(text_rd_reg)
                      && ((PTR_W+1)'(pointer_reg) < (PTR_W+1)'(letter_total_reg));
    assign pointer_sum = (PTR_W+1)'(pointer_reg) + (PTR_W+1)'(rods);

    // Next-state logic
    always_comb
    begin
        state_next        = state_reg;
        text_count_next   = text_count_reg;
        letter_total_next = letter_total_reg;
        out_position_next = out_position_reg;
        column_next       = column_reg;
        pointer_next      = pointer_reg;
        loaded_next       = loaded_reg;
        emitting_next     = emitting_reg;
        out_valid_next    = 1'b0;
        out_byte_next     = out_byte_reg;
        out_last_next     = out_last_reg;
        out_none_next     = out_none_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_req)
                begin
                    if (new_msg)
                    begin
                        out_position_next = '0;
                        column_next       = '0;
                        pointer_next      = '0;
                        emitting_next     = 1'b0;
                        loaded_next       = 1'b0;
                    end
                    text_count_next   = text_room ? base_text + 1'b1 : base_text;
                    letter_total_next = letter_wr ? base_letter + 1'b1 : base_letter;
                    if (in_last)
                    begin
                        loaded_next = 1'b1;
                    end
                end
                else if (fetch_req)
                begin
                    emitting_next = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                if (at_end)
                begin
                    out_byte_next = 8'd0;
                    out_last_next = 1'b0;
                    out_none_next = 1'b1;
                end
                else
                begin
                    out_byte_next     = use_letter ? letter_rd_reg : text_rd_reg;
                    out_last_next     = ((out_position_reg + 1'b1) == text_count_reg);
                    out_none_next     = 1'b0;
                    out_position_next = out_position_reg + 1'b1;
                    if (use_letter)
                    begin
                        // step one row down; past the end, top of next column
                        if (pointer_sum >= (PTR_W+1)'(letter_total_reg))
                        begin
                            column_next  = column_reg + 8'd1;
                            pointer_next = PTR_W'(column_reg + 8'd1);
                        end
                        else
                        begin
                            pointer_next = pointer_sum[PTR_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            text_count_reg   <= '0;
            letter_total_reg <= '0;
            out_position_reg <= '0;
            column_reg       <= '0;
            pointer_reg      <= '0;
            loaded_reg       <= 1'b0;
            emitting_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            text_count_reg   <= text_count_next;
            letter_total_reg <= letter_total_next;
            out_position_reg <= out_position_next;
            column_reg       <= column_next;
            pointer_reg      <= pointer_next;
            loaded_reg       <= loaded_next;
            emitting_reg     <= emitting_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_none_reg <= out_none_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_none  = out_none_reg;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rod_count_reg <= ROD_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_ROD_COUNT))
        begin
            rod_count_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROD_COUNT) ? {24'd0, rod_count_reg} : 32'd0;

`ifndef ASSERT_OFF
    // A result only ever follows a memory read cycle
    a_result_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(state_reg == ST_READ))
        else $error("result without preceding read cycle");

    // Letters are a subset of the stored text
    a_letters_within_text: assert property (@(posedge clk) disable iff (!rst_n)
        letter_total_reg <= text_count_reg)
        else $error("letter count exceeds text count");

    // Text count never passes the capacity
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        text_count_reg <= CNT_W'(MAX_LEN))
        else $error("text count beyond capacity");

    // A delivered byte advances the output position by one
    a_position_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_none |-> out_position_reg == $past(out_position_reg) + 1'b1
                                   || $past(load_req))
        else $error("output position did not advance");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the scytale letter transposer.
// Predicts every fetched byte from its own copy of the text and letter stores.
// Depends on slt_pkg and scytale_letter_transposer_top.
module testbench;
    import slt_pkg::*;

    localparam int unsigned CAPACITY     = MAX_LEN_DEFAULT;
    localparam int          CW           = $clog2(CAPACITY) + 1;
    localparam int          RANDOM_ITEMS = 250;
    localparam int          CAP_FETCHES  = 48;

    // APB byte addresses: 4 * register index
    localparam logic [1:0] REG_SPARE  = 2'd1;
    localparam logic [2:0] ADDR_RODS  = {REG_ROD_COUNT, 2'b00};
    localparam logic [2:0] ADDR_SPARE = {REG_SPARE[0], 2'b00};

    typedef struct packed {
        logic [7:0] text;
        logic       last;
        logic       none;
    } fetch_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        action = ACT_LOAD;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        out_none;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted block state
    logic [7:0]    text_mem   [CAPACITY];
    logic [7:0]    letter_mem [CAPACITY];
    logic [CW-1:0] text_len;
    logic [CW-1:0] letter_len;
    logic [CW-1:0] read_pos;
    logic [CW-1:0] letter_idx;
    logic [7:0]    column;
    logic          msg_closed;
    logic          msg_reading;
    logic [7:0]    rods;

    fetch_result_t due_outputs[$];

    int errors       = 0;
    int n_loads      = 0;
    int n_fetches    = 0;
    int n_checked    = 0;
    int n_rod_writes = 0;
    bit idle_on      = 1'b1;

    scytale_letter_transposer_top #(
        .MAX_LEN (CAPACITY)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_none  (out_none),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Letter test by case folding
    function automatic bit is_alpha(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (folded >= CHAR_LOWER_A) && (folded <= CHAR_LOWER_Z);
    endfunction

    function automatic void restart_message();
        text_len    = '0;
        letter_len  = '0;
        read_pos    = '0;
        letter_idx  = '0;
        column      = 8'd0;
        msg_closed  = 1'b0;
        msg_reading = 1'b0;
    endfunction

    function automatic void predict_load(input logic [7:0] b, input logic lst);
        if (msg_closed || msg_reading)
            restart_message();
        // bytes beyond capacity are dropped, in_last still counts
        if (text_len < CAPACITY)
        begin
            text_mem[text_len] = b;
            text_len++;
            if (is_alpha(b))
            begin
                letter_mem[letter_len] = b;
                letter_len++;
            end
        end
        if (lst)
            msg_closed = 1'b1;
    endfunction

    function automatic fetch_result_t predict_fetch();
        fetch_result_t r;
        logic [7:0]    c;
        logic [CW-1:0] step;
        msg_reading = 1'b1;
        if (read_pos >= text_len)
        begin
            r = '{text: 8'h00, last: 1'b0, none: 1'b1};
        end
        else
        begin
            c    = text_mem[read_pos];
            step = {{(CW-8){1'b0}}, rods};
            if (rods == 8'd0)
                step = CW'(1);
            // letter slot: next letter down the current column of the grid
            if (is_alpha(c) && letter_idx < letter_len)
            begin
                c = letter_mem[letter_idx];
                letter_idx = letter_idx + step;
                if (letter_idx >= letter_len)
                begin
                    column     = column + 8'd1;
                    letter_idx = {{(CW-8){1'b0}}, column};
                end
            end
            r = '{text: c, last: (read_pos + 1 == text_len), none: 1'b0};
            read_pos++;
        end
        return r;
    endfunction

    function automatic logic [7:0] random_text_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick < 3)
            return 8'(CHAR_UPPER_A + $urandom_range(0, 25));
        else if (pick < 6)
            return 8'(CHAR_LOWER_A + $urandom_range(0, 25));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_rods();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'($urandom_range(13, 254));
            default: return 8'($urandom_range(2, 12));
        endcase
    endfunction

    // Issue one request; start stays high on return so back-to-back requests flow
    task automatic send_request(input logic act, input logic [7:0] b, input logic lst);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        action  <= act;
        in_byte <= b;
        in_last <= lst;
        do @(posedge clk); while (busy !== 1'b0);
        if (act == ACT_LOAD)
        begin
            predict_load(b, lst);
            n_loads++;
        end
        else
        begin
            due_outputs.push_back(predict_fetch());
            n_fetches++;
        end
    endtask

    task automatic load_byte(input logic [7:0] b, input logic lst);
        send_request(ACT_LOAD, b, lst);
    endtask

    // in_byte and in_last carry noise on a fetch
    task automatic fetch_one();
        send_request(ACT_FETCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Stop requesting and let every outstanding fetch come back
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (addr == ADDR_RODS)
            rods = data[7:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write rod_count when idle, poke the unmapped slot, read back
    task automatic set_rods(input logic [7:0] value);
        logic [31:0] word;
        logic [31:0] back;
        settle();
        word = $urandom;
        word[7:0] = value;
        apb_write(ADDR_RODS, word);
        apb_write(ADDR_SPARE, $urandom);
        apb_read(ADDR_RODS, back);
        if (back[7:0] !== rods)
        begin
            errors++;
            $display("%0t: rod_count readback expected %0d actual %0d",
                     $time, rods, back[7:0]);
        end
        n_rod_writes++;
    endtask

    task automatic test_directed();
        logic [7:0] probe_bytes[10];
        probe_bytes = '{8'h00, CHAR_UPPER_A, CHAR_LOWER_Z, 8'hFF, CHAR_UPPER_Z,
                        CHAR_LOWER_A, 8'h40, 8'h5B, 8'h60, 8'h7B};
        // fetch with nothing loaded
        fetch_one();
        foreach (probe_bytes[i])
            load_byte(probe_bytes[i], i == 9);
        repeat (11) fetch_one();
        settle();
    endtask

    // Short messages under the rod extremes and a few ordinary grids
    task automatic test_rod_settings();
        logic [7:0] settings[5];
        settings = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3};
        foreach (settings[s])
        begin
            set_rods(settings[s]);
            for (int i = 0; i < 14; i++)
                load_byte((i % 5 == 4) ? 8'h20 : random_text_byte(), i == 13);
            repeat (15) fetch_one();
        end
        settle();
    endtask

    task automatic test_restart();
        set_rods(8'd3);
        // fetch before in_last, then a load starts a new message
        for (int i = 0; i < 8; i++)
            load_byte(random_text_byte(), 1'b0);
        repeat (3) fetch_one();
        for (int i = 0; i < 6; i++)
            load_byte(random_text_byte(), i == 5);
        repeat (7) fetch_one();
        // load after in_last with no fetch also restarts
        for (int i = 0; i < 5; i++)
            load_byte(random_text_byte(), i == 4);
        for (int i = 0; i < 4; i++)
            load_byte(8'(CHAR_LOWER_A + i), i == 3);
        repeat (5) fetch_one();
        // rods changed part way through the output
        for (int i = 0; i < 20; i++)
            load_byte(8'(CHAR_UPPER_A + $urandom_range(0, 25)), i == 19);
        repeat (6) fetch_one();
        set_rods(8'd5);
        repeat (9) fetch_one();
        set_rods(8'd0);
        repeat (7) fetch_one();
        // wide jump leaves letters unconsumed when the pointer runs off
        for (int i = 0; i < 10; i++)
            load_byte(8'(CHAR_LOWER_A + $urandom_range(0, 25)), i == 9);
        set_rods(8'd2);
        repeat (3) fetch_one();
        set_rods(8'd9);
        repeat (9) fetch_one();
        settle();
    endtask

    // One message longer than the text store; read back the start of it
    task automatic test_capacity();
        set_rods(8'($urandom_range(2, 40)));
        for (int i = 0; i < CAPACITY + 6; i++)
            load_byte(random_text_byte(), i == CAPACITY + 5);
        repeat (CAP_FETCHES) fetch_one();
        settle();
    endtask

    task automatic test_random();
        int base;
        int len;
        int mode;
        base = n_loads + n_fetches;
        while (n_loads + n_fetches - base < RANDOM_ITEMS)
        begin
            // final stretch runs without gaps
            if (n_loads + n_fetches - base > RANDOM_ITEMS * 85 / 100)
                idle_on = 1'b0;
            if ($urandom_range(0, 5) == 0)
                set_rods(pick_rods());
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                              : $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
                load_byte(random_text_byte(), (i == len - 1) && ($urandom_range(0, 6) != 0));
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                // partial read-out, abandoned by the next message
                repeat ($urandom_range(0, len)) fetch_one();
            end
            else if (mode == 1)
            begin
                repeat (len / 2) fetch_one();
                set_rods(pick_rods());
                repeat (len - len / 2 + 1) fetch_one();
            end
            else if (mode == 2)
            begin
                // noise: loads and fetches mixed at random
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 1))
                        load_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    else
                        fetch_one();
                end
            end
            else
            begin
                repeat (len + $urandom_range(0, 2)) fetch_one();
            end
        end
        settle();
    endtask

    // Compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin
        fetch_result_t want;
        if (rst_n && out_valid === 1'b1)
        begin
            if (due_outputs.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, actual byte %h last %b none %b",
                         $time, out_byte, out_last, out_none);
            end
            else
            begin
                want = due_outputs.pop_front();
                n_checked++;
                if (out_byte !== want.text)
                begin
                    errors++;
                    $display("%0t: out_byte expected %h actual %h", $time, want.text, out_byte);
                end
                if (out_last !== want.last)
                begin
                    errors++;
                    $display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
                end
                if (out_none !== want.none)
                begin
                    errors++;
                    $display("%0t: out_none expected %b actual %b", $time, want.none, out_none);
                end
            end
        end
    end

    initial
    begin
        rods = ROD_RESET;
        restart_message();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_rod_settings();
        test_restart();
        test_capacity();
        test_random();

        if (due_outputs.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, due_outputs.size());
        end
        $display("Sent %0d loads and %0d fetches; compared %0d results over %0d rod settings.",
                 n_loads, n_fetches, n_checked, n_rod_writes);
        $display("Covered restarts, reads before the end mark, capacity overflow and rod changes.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("%0t: timed out with %0d results outstanding", $time, due_outputs.size());
        $display("status: fail");
        $finish;
    end

endmodule
